>>> rtl/core/tps_pkg.sv
`timescale 1ns / 1ps
package tps_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int CORDIC_ITER = 20;
  localparam int GUARD       = 8;
  localparam int POS_W       = 32;
  localparam int LIM_W       = 16;
  localparam int CW          = 44;                 // CORDIC x/y datapath width
  localparam int ZW          = 34;                 // CORDIC angle accumulator width
  localparam int NUM_W       = 41;                 // signed wrap numerator width
  localparam int L_W         = LIM_W + FRAC_BITS;  // wrap modulus width
  localparam int DIST_W      = 36;
  localparam int IT_W        = $clog2(CORDIC_ITER + 1);
  localparam int MC_W        = $clog2(NUM_W + 1);
  localparam logic [31:0] INV_GAIN = 32'h9B74EDA9;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_STEP  = 2'd1,
    REQ_MOVE  = 2'd2,
    REQ_QUERY = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_NEAR   = 2'd2
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_VEC, ST_GAIN_HI, ST_GAIN_LO, ST_DECIDE,
    ST_ROT_LOAD, ST_ROT, ST_MODX_GO, ST_MODX_WAIT, ST_MODY_GO, ST_MODY_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       load;
    logic       step;
    logic       vec_mode;
    logic [4:0] idx;
  } cordic_ctrl_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/tps_cordic.sv
`timescale 1ns / 1ps
module tps_cordic (
  input  logic                         clk_i,
  input  tps_pkg::cordic_ctrl_t        ctrl_i,
  input  logic signed [tps_pkg::CW-1:0] x0_i,
  input  logic signed [tps_pkg::CW-1:0] y0_i,
  input  logic signed [tps_pkg::ZW-1:0] z0_i,
  output logic signed [tps_pkg::CW-1:0] x_o,
  output logic signed [tps_pkg::CW-1:0] y_o,
  output logic signed [tps_pkg::ZW-1:0] z_o
);
  import tps_pkg::*;

  logic signed [CW-1:0] x_q, y_q, x_d, y_d, xs, ys;
  logic signed [ZW-1:0] z_q, z_d, a;
  logic                 up;

  // one micro-rotation per cycle while step is set, direction from y (vectoring) or angle (rotation)
  always_comb begin
    xs  = x_q >>> ctrl_i.idx;
    ys  = y_q >>> ctrl_i.idx;
    a   = ZW'($signed({2'b00, atan_turn(ctrl_i.idx)}));
    up  = ctrl_i.vec_mode ? ~y_q[CW-1] : z_q[ZW-1];
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (ctrl_i.load) begin
      x_d = x0_i;
      y_d = y0_i;
      z_d = z0_i;
    end else if (ctrl_i.step) begin
      if (up) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + a;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - a;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

>>> rtl/core/tps_wrap.sv
`timescale 1ns / 1ps
module tps_wrap (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [tps_pkg::NUM_W-1:0]  num_i,
  input  logic [tps_pkg::LIM_W-1:0]         lim_i,
  output logic                              done_o,
  output logic [tps_pkg::POS_W-1:0]         rem_o
);
  import tps_pkg::*;

  logic             busy_q, busy_d, neg_q, neg_d, done_q, done_d;
  logic [MC_W-1:0]  cnt_q, cnt_d;
  logic [NUM_W-1:0] mag_q, mag_d;
  logic [L_W:0]     r_q, r_d, t;
  logic [L_W-1:0]   l_q, l_d, fin;

  // restoring remainder of |num| by limit, one bit per cycle, then floor fix
  always_comb begin
    busy_d = busy_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    r_d    = r_q;
    l_d    = l_q;
    done_d = 1'b0;
    t      = {r_q[L_W-1:0], mag_q[NUM_W-1]};
    fin    = (neg_q && r_q != '0) ? l_q - r_q[L_W-1:0] : r_q[L_W-1:0];
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = num_i[NUM_W-1];
      mag_d  = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      r_d    = '0;
      cnt_d  = '0;
      l_d    = {(lim_i == '0) ? LIM_W'(1) : lim_i, {FRAC_BITS{1'b0}}};
    end else if (busy_q) begin
      mag_d = mag_q << 1;
      r_d   = (t >= {1'b0, l_q}) ? t - {1'b0, l_q} : t;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == MC_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
    r_q   <= r_d;
    l_q   <= l_d;
  end

  assign done_o = done_q;
  assign rem_o  = POS_W'(fin);

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> r_q < {1'b0, l_q}) else $error("remainder not below modulus");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("wrap restarted while busy");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held over two cycles");

endmodule

>>> rtl/core/toroidal_point_stepper_core.sv
`timescale 1ns / 1ps
// Sequence: load goes straight to the output; move runs the bit-serial wrap remainder
//   once per coordinate; query runs the CORDIC vectoring loop; step runs vectoring, the
//   CORDIC rotation loop unless snapping, then the wrap remainder once per coordinate.
// Throughput: one request at a time; the next is taken once the previous one is in
//   the output register.
// Reset (rst_ni low, asynchronous): position 0, width/height 1024, tolerance 3277.
module toroidal_point_stepper_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // target_x, target_y, step_amount, dir_x, dir_y, speed
  input  logic [1:0]   s_axis_tuser,  // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata,  // pos_x, pos_y, reached, distance, angle, near, zero pad
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i
);
  import tps_pkg::*;

  state_e state_q, state_d;
  logic [1:0]       req_q;
  logic [31:0]      tx_q, ty_q, amt_q, pos_x_q, pos_y_q;
  logic signed [7:0] dirx_q, diry_q;
  logic [15:0]      spd_q, wl_q, hl_q, tol_q;
  logic [IT_W-1:0]  it_q, it_d;
  logic [59:0]      hi_q;
  logic [DIST_W-1:0] dist_q, dist_d;
  logic [31:0]      ang_q;
  logic             reached_q, snap_q;
  logic             out_valid_q;
  logic [119:0]     out_q;

  cordic_ctrl_t         cc;
  logic signed [CW-1:0] cx0, cy0, cx, cy;
  logic signed [ZW-1:0] cz0, cz;
  logic [31:0]          mul_a, mul_b;
  logic [63:0]          prod;
  logic                 wstart, wdone;
  logic signed [NUM_W-1:0] wnum;
  logic [LIM_W-1:0]     wlim;
  logic [31:0]          wrem;
  logic signed [40:0]   dx, dy;
  logic signed [CW-9:0] ox, oy;
  logic signed [CW-1:0] rx;
  logic [31:0]          zr;
  logic signed [23:0]   mvx, mvy;
  logic                 accept, last_it, out_free;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign last_it  = (it_q == IT_W'(CORDIC_ITER - 1));
  assign out_free = !out_valid_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (accept) state_d = ST_DECODE;
      ST_DECODE: begin
        case (req_q)
          REQ_LOAD: state_d = ST_DONE;
          REQ_MOVE: state_d = ST_MODX_GO;
          default:  state_d = ST_VEC;
        endcase
      end
      ST_VEC:       if (last_it) state_d = ST_GAIN_HI;
      ST_GAIN_HI:   state_d = ST_GAIN_LO;
      ST_GAIN_LO:   state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (req_q != REQ_STEP) state_d = ST_DONE;
        else if (dist_q < {4'b0, amt_q}) state_d = ST_MODX_GO;
        else state_d = ST_ROT_LOAD;
      end
      ST_ROT_LOAD:  state_d = ST_ROT;
      ST_ROT:       if (last_it) state_d = ST_MODX_GO;
      ST_MODX_GO:   state_d = ST_MODX_WAIT;
      ST_MODX_WAIT: if (wdone) state_d = ST_MODY_GO;
      ST_MODY_GO:   state_d = ST_MODY_WAIT;
      ST_MODY_WAIT: if (wdone) state_d = ST_DONE;
      ST_DONE:      if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // datapath control and operand selection
  always_comb begin
    dx    = 41'(signed'({1'b0, tx_q})) - 41'(signed'({1'b0, pos_x_q}));
    dy    = 41'(signed'({1'b0, ty_q})) - 41'(signed'({1'b0, pos_y_q}));
    ox    = (CW-8)'((cx + CW'(1 << (GUARD - 1))) >>> GUARD);
    oy    = (CW-8)'((cy + CW'(1 << (GUARD - 1))) >>> GUARD);
    mvx   = dirx_q * $signed({1'b0, spd_q});
    mvy   = diry_q * $signed({1'b0, spd_q});
    zr    = ang_q;
    rx    = CW'(signed'({1'b0, prod[63:24]}));
    cc    = '0;
    cc.idx = it_q[4:0];
    cx0   = '0;
    cy0   = '0;
    cz0   = '0;
    mul_a = '0;
    mul_b = INV_GAIN;
    dist_d = dist_q;
    it_d  = '0;
    wstart = 1'b0;
    wnum  = '0;
    wlim  = wl_q;
    case (state_q)
      ST_DECODE: begin
        cc.load = 1'b1;
        if (dx < 0) begin
          if (dy >= 0) begin
            cx0 = CW'(dy) <<< GUARD;
            cy0 = CW'(-dx) <<< GUARD;
            cz0 = ZW'(34'h040000000);
          end else begin
            cx0 = CW'(-dy) <<< GUARD;
            cy0 = CW'(dx) <<< GUARD;
            cz0 = ZW'(34'h0C0000000);
          end
        end else begin
          cx0 = CW'(dx) <<< GUARD;
          cy0 = CW'(dy) <<< GUARD;
        end
      end
      ST_VEC: begin
        cc.step = 1'b1;
        cc.vec_mode = 1'b1;
        it_d = it_q + 1'b1;
      end
      ST_GAIN_HI: mul_a = 32'(cx[CW-1:16]);
      ST_GAIN_LO: begin
        mul_a  = {16'b0, cx[15:0]};
        dist_d = DIST_W'((61'(hi_q) + 61'(prod[63:16])) >> 24);
      end
      ST_ROT_LOAD: begin
        mul_a   = amt_q;
        cc.load = 1'b1;
        if (zr[31:30] == 2'd1 || zr[31:30] == 2'd2) begin
          cx0 = -rx;
          zr  = ang_q + 32'h80000000;
        end else begin
          cx0 = rx;
        end
        cz0 = ZW'($signed(zr));
      end
      ST_ROT: begin
        cc.step = 1'b1;
        it_d = it_q + 1'b1;
      end
      ST_MODX_GO: begin
        wstart = 1'b1;
        if (req_q == REQ_MOVE)
          wnum = NUM_W'(signed'({1'b0, pos_x_q})) + (NUM_W'(mvx) <<< FRAC_BITS);
        else if (snap_q) wnum = NUM_W'(signed'({1'b0, tx_q}));
        else wnum = NUM_W'(signed'({1'b0, pos_x_q})) + NUM_W'(ox);
      end
      ST_MODY_GO: begin
        wstart = 1'b1;
        wlim   = hl_q;
        if (req_q == REQ_MOVE)
          wnum = NUM_W'(signed'({1'b0, pos_y_q})) + (NUM_W'(mvy) <<< FRAC_BITS);
        else if (snap_q) wnum = NUM_W'(signed'({1'b0, ty_q}));
        else wnum = NUM_W'(signed'({1'b0, pos_y_q})) + NUM_W'(oy);
      end
      ST_MODY_WAIT: wlim = hl_q;
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  tps_cordic u_cordic (
    .clk_i  (clk_i),
    .ctrl_i (cc),
    .x0_i   (cx0),
    .y0_i   (cy0),
    .z0_i   (cz0),
    .x_o    (cx),
    .y_o    (cy),
    .z_o    (cz)
  );

  tps_wrap u_wrap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (wstart),
    .num_i   (wnum),
    .lim_i   (wlim),
    .done_o  (wdone),
    .rem_o   (wrem)
  );

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      it_q        <= '0;
      out_valid_q <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      wl_q        <= 16'd1024;
      hl_q        <= 16'd1024;
      tol_q       <= 16'd3277;
    end else begin
      state_q <= state_d;
      it_q    <= it_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIDTH:  wl_q  <= cfg_data_i;
          CFG_HEIGHT: hl_q  <= cfg_data_i;
          CFG_NEAR:   tol_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_DECODE && req_q == REQ_LOAD) begin
        pos_x_q <= tx_q;
        pos_y_q <= ty_q;
      end
      if (state_q == ST_MODX_WAIT && wdone) pos_x_q <= wrem;
      if (state_q == ST_MODY_WAIT && wdone) pos_y_q <= wrem;
      if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // capture the request, results and the output register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q     <= s_axis_tuser;
      tx_q      <= s_axis_tdata[31:0];
      ty_q      <= s_axis_tdata[63:32];
      amt_q     <= s_axis_tdata[95:64];
      dirx_q    <= s_axis_tdata[103:96];
      diry_q    <= s_axis_tdata[111:104];
      spd_q     <= s_axis_tdata[127:112];
      dist_q    <= '0;
      ang_q     <= '0;
      reached_q <= 1'b0;
      snap_q    <= 1'b0;
    end
    if (state_q == ST_GAIN_HI) hi_q <= prod[59:0];
    if (state_q == ST_GAIN_LO) begin
      dist_q <= dist_d;
      ang_q  <= cz[31:0];
    end
    if (state_q == ST_DECIDE && req_q == REQ_STEP && dist_q < {4'b0, amt_q}) begin
      snap_q    <= 1'b1;
      reached_q <= 1'b1;
    end
    if (state_q == ST_DONE && out_free) begin
      out_q <= {5'b0,
                (req_q[0] && dist_q < {20'b0, tol_q}),
                16'(((ang_q + 32'h8000) >> 16)),
                dist_q[32:0], reached_q, pos_y_q, pos_x_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready) else $error("took a request while busy");
  a_reached_means_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && reached_q) |-> dist_q < {4'b0, amt_q})
    else $error("snap without short distance");
  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside completion");

endmodule
